/* rtl/btsc_pkg.sv */
// Shared types and constants for the boosted-tree soft-cascade scorer.
package btsc_pkg;

  // Operation codes carried on s_tuser
  typedef enum logic [1:0] {
    OP_NODE_WR = 2'd0,
    OP_FEAT_WR = 2'd1,
    OP_EVAL    = 2'd2
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_CASCADE_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_TREE_COUNT        = 2'd1;
  localparam logic [1:0] CFG_NODES_PER_TREE    = 2'd2;

  // Fixed field widths
  localparam int unsigned FIELD_BITS   = 32;
  localparam int unsigned NODE_IDX_BITS = 14;
  localparam int unsigned FEAT_ID_BITS = 13;
  localparam int unsigned CHILD_BITS   = 8;
  localparam int unsigned TREES_BITS   = 13;

  // Register reset values
  localparam logic signed [31:0] CASCADE_THRESHOLD_RST = -32'sd65536;
  localparam logic [12:0]        TREE_COUNT_RST        = 13'd2048;
  localparam logic [7:0]         NODES_PER_TREE_RST    = 8'd7;

  // One node slot as stored
  typedef struct packed {
    logic [FEAT_ID_BITS-1:0]      feature_id;
    logic signed [FIELD_BITS-1:0] threshold;
    logic [CHILD_BITS-1:0]        child;
    logic signed [FIELD_BITS-1:0] leaf_value;
  } node_t;

endpackage

/* rtl/boosted_tree_soft_cascade.sv */
// Soft-cascade scorer over a store of boosted decision trees, one shared add/compare unit.
//
// Channel  Dir  Handshake          Payload
// s_*      in   tvalid/tready      tuser: operation; tdata: node and feature write fields
// m_*      out  tvalid/tready      tdata: score, detected
// cfg_*    in   we (no wait)       index selects threshold, tree count or node stride
//
// An evaluate item walks each visited tree from its root: every descent reads a feature
// and the child node, and every tree ends in a leaf add and a cascade check. Its pace is
// set by the node and feature memory reads (registered, each behind a wait state)
// and by the single adder/comparator doing every split test, leaf add and cascade check.
// s_tready is high only in idle; a finished result waits in the output register
// while further items are taken, and a second result waits in the sequencer for it.
// Reset (synchronous) restores the register defaults; node and feature memories
// are not cleared and hold garbage until written. NODE_SLOTS and FEATURE_SLOTS
// are powers of two, so address wrap is a truncation.
module boosted_tree_soft_cascade #(
  parameter int unsigned NODE_SLOTS    = 16384,
  parameter int unsigned FEATURE_SLOTS = 8192,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // node_index[13:0], node_feature_id[26:14],
                                  // node_threshold[58:27], node_child[66:59],
                                  // node_leaf_value[98:67], feature_index[111:99],
                                  // feature_value[143:112]
  input  logic [1:0]   s_tuser,   // operation[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // score[31:0], detected[32], zero[39:33]
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned NA = $clog2(NODE_SLOTS);
  localparam int unsigned FA = $clog2(FEATURE_SLOTS);
  localparam int unsigned MW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int unsigned AW = MW + 2;
  localparam longint AccHi = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
  localparam longint AccLo = -AccHi - 1;
  localparam longint ScoreHi = 64'sd2147483647;
  localparam longint ScoreLo = -64'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE, S_NWAIT, S_NODE, S_FWAIT, S_FEAT, S_CHK, S_OUT
  } state_t;

  // Configuration registers
  logic signed [31:0] cascade_threshold;
  logic [12:0]        tree_count;
  logic [7:0]         nodes_per_tree;

  always_ff @(posedge clk) begin
    if (rst) begin
      cascade_threshold <= btsc_pkg::CASCADE_THRESHOLD_RST;
      tree_count        <= btsc_pkg::TREE_COUNT_RST;
      nodes_per_tree    <= btsc_pkg::NODES_PER_TREE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        btsc_pkg::CFG_CASCADE_THRESHOLD: cascade_threshold <= cfg_data;
        btsc_pkg::CFG_TREE_COUNT:        tree_count        <= cfg_data[12:0];
        btsc_pkg::CFG_NODES_PER_TREE:    nodes_per_tree    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input unpacking
  logic [13:0]        in_node_index;
  logic [12:0]        in_feature_index;
  logic signed [31:0] in_feature_value;
  btsc_pkg::node_t    in_node;

  assign in_node_index         = s_tdata[13:0];
  assign in_node.feature_id    = s_tdata[26:14];
  assign in_node.threshold     = s_tdata[58:27];
  assign in_node.child         = s_tdata[66:59];
  assign in_node.leaf_value    = s_tdata[98:67];
  assign in_feature_index      = s_tdata[111:99];
  assign in_feature_value      = s_tdata[143:112];

  logic [31:0] node_wr_wide;
  logic [31:0] feat_wr_wide;
  logic [31:0] fid_wide;
  assign node_wr_wide = 32'(in_node_index);
  assign feat_wr_wide = 32'(in_feature_index);

  // Sequencer state
  state_t             state;
  logic [NA-1:0]      node_addr;
  logic [FA-1:0]      feat_addr;
  logic [NA-1:0]      base;
  logic [7:0]         steps;
  logic [12:0]        trees_done;
  logic signed [VALUE_BITS-1:0] acc;

  // Memories, read data registered
  btsc_pkg::node_t    node_mem [NODE_SLOTS];
  logic signed [31:0] feat_mem [FEATURE_SLOTS];
  btsc_pkg::node_t    node_q;
  logic signed [31:0] feat_q;

  logic s_fire;
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (s_fire && s_tuser == btsc_pkg::OP_NODE_WR) begin
      node_mem[node_wr_wide[NA-1:0]] <= in_node;
    end
    node_q <= node_mem[node_addr];
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_tuser == btsc_pkg::OP_FEAT_WR) begin
      feat_mem[feat_wr_wide[FA-1:0]] <= in_feature_value;
    end
    feat_q <= feat_mem[feat_addr];
  end

  // Shared adder/subtractor: split test, leaf accumulate, cascade check
  logic signed [AW-1:0] alu_a, alu_b, alu_y;
  logic                 alu_sub;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_FEAT: begin
        alu_a   = AW'(feat_q);
        alu_b   = AW'(node_q.threshold);
        alu_sub = 1'b1;
      end
      S_NODE: begin
        alu_a = AW'(acc);
        alu_b = AW'(node_q.leaf_value);
      end
      S_CHK: begin
        alu_a   = AW'(acc);
        alu_b   = AW'(cascade_threshold);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // Saturation of the accumulate result to VALUE_BITS
  logic signed [VALUE_BITS-1:0] acc_sat;
  always_comb begin
    if (alu_y > AW'(AccHi))      acc_sat = VALUE_BITS'(AccHi);
    else if (alu_y < AW'(AccLo)) acc_sat = VALUE_BITS'(AccLo);
    else                         acc_sat = alu_y[VALUE_BITS-1:0];
  end

  // Score clamped to 32 bits for the result
  logic signed [AW-1:0] acc_wide;
  logic signed [31:0]   score_clamp;
  assign acc_wide = AW'(acc);
  always_comb begin
    if (acc_wide > AW'(ScoreHi))      score_clamp = 32'(ScoreHi);
    else if (acc_wide < AW'(ScoreLo)) score_clamp = 32'(ScoreLo);
    else                              score_clamp = acc_wide[31:0];
  end

  logic          go_left;
  logic          reject;
  logic          descend;
  logic [NA:0]   child_tgt;
  logic [NA:0]   base_sum;

  assign go_left   = alu_y[AW-1];
  assign reject    = alu_y[AW-1] || (alu_y == '0);
  assign descend   = (node_q.child != '0) && (steps < nodes_per_tree);
  assign child_tgt = {1'b0, base} + (NA+1)'(node_q.child) - (NA+1)'(go_left);
  assign base_sum  = {1'b0, base} + (NA+1)'(nodes_per_tree);
  assign fid_wide  = 32'(node_q.feature_id);

  logic        detected;
  logic        out_load;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_fire && s_tuser == btsc_pkg::OP_EVAL) begin
            acc        <= '0;
            base       <= '0;
            node_addr  <= '0;
            steps      <= '0;
            trees_done <= '0;
            // no trees: straight to the final check with a zero score
            state      <= (tree_count == '0) ? S_CHK : S_NWAIT;
          end
        end
        S_NWAIT: state <= S_NODE;
        S_NODE: begin
          if (descend) begin
            feat_addr <= fid_wide[FA-1:0];
            state     <= S_FWAIT;
          end else begin
            acc        <= acc_sat;
            trees_done <= trees_done + 13'd1;
            state      <= S_CHK;
          end
        end
        S_FWAIT: state <= S_FEAT;
        S_FEAT: begin
          node_addr <= child_tgt[NA-1:0];
          steps     <= steps + 8'd1;
          state     <= S_NWAIT;
        end
        S_CHK: begin
          if (reject || trees_done == tree_count) begin
            detected <= !reject;
            state    <= S_OUT;
          end else begin
            base      <= base_sum[NA-1:0];
            node_addr <= base_sum[NA-1:0];
            steps     <= '0;
            state     <= S_NWAIT;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // Output register
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'd0, detected, score_clamp};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_feat_after_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_FEAT |-> $past(state) == S_FWAIT)
    else $error("split test without feature read");

  a_chk_source: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> ($past(state) == S_NODE || $past(state) == S_IDLE))
    else $error("cascade check entered from wrong state");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_NODE || state == S_FEAT) |-> !s_tready)
    else $error("input taken during tree walk");
`endif

endmodule
